// ----- sv/ptts_pkg.sv -----
package ptts_pkg;

    localparam int SLOT_W      = 3;
    localparam int TIME_W      = 16;
    localparam int MODE_W      = 3;
    localparam int MAX_SLOTS   = 8;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_CREATE  = 3'd1,
        MODE_SUSPEND = 3'd2,
        MODE_RESUME  = 3'd3,
        MODE_DELETE  = 3'd4
    } mode_t;

    typedef enum logic {
        KIND_DISPATCH = 1'b0,
        KIND_CREATE   = 1'b1
    } kind_t;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_TAKEN = 1'b1
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    typedef struct packed {
        mode_t             op;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] delay;
        logic              has_func;
    } cmd_t;

endpackage

// ----- sv/ptts_front.sv -----
module ptts_front
    import ptts_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // task_slot[2:0], period[18:3], first_delay[34:19], has_function[35], zero fill
    input  logic [IN_DATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    cmd_t in_cmd;
    logic keep;
    logic push;
    logic pop;

    always_comb begin
        in_cmd.op       = mode_t'(s_tuser);
        in_cmd.slot     = s_tdata[2:0];
        in_cmd.in_range = ({1'b0, s_tdata[2:0]} < 4'(NUM_SLOTS));
        in_cmd.period   = s_tdata[18:3];
        in_cmd.delay    = s_tdata[34:19];
        in_cmd.has_func = s_tdata[35];
    end

    // drop unused codes and flag updates aimed past the table
    always_comb begin
        unique case (in_cmd.op)
            MODE_TICK, MODE_CREATE: keep = 1'b1;
            MODE_SUSPEND, MODE_RESUME, MODE_DELETE: keep = in_cmd.in_range;
            default: keep = 1'b0;
        endcase
    end

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- sv/ptts_back.sv -----
module ptts_back
    import ptts_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_out[2:0], status[3], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    back_state_t state_reg, state_next;
    logic [IDX_W-1:0] scan_reg, scan_next;

    logic              occupied_reg  [NUM_SLOTS];
    logic              running_reg   [NUM_SLOTS];
    logic [TIME_W-1:0] period_reg    [NUM_SLOTS];
    logic [TIME_W-1:0] countdown_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] fire_reg;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic              out_free;
    logic [IDX_W-1:0]  cidx;
    logic              slot_free;
    logic              scan_go;
    logic              start_tick;
    logic              load_out;
    kind_t             out_kind;
    logic [SLOT_W-1:0] out_slot;
    status_t           out_status;
    logic              out_last;
    logic              do_create;
    logic              do_suspend;
    logic              do_resume;
    logic              do_delete;
    logic              do_count;

    assign out_free  = !out_valid_reg || m_tready;
    assign cidx      = cmd.slot[IDX_W-1:0];
    assign slot_free = cmd.in_range && !occupied_reg[cidx];
    assign scan_go   = !fire_reg[scan_reg] || out_free;

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd.op == MODE_TICK) begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                end
            end
            ST_SCAN: begin
                if (scan_go) begin
                    scan_next = scan_reg + IDX_W'(1);
                    if (scan_reg == IDX_W'(NUM_SLOTS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready  = 1'b0;
        start_tick = 1'b0;
        load_out   = 1'b0;
        out_kind   = KIND_DISPATCH;
        out_slot   = cmd.slot;
        out_status = STATUS_OK;
        out_last   = 1'b1;
        do_create  = 1'b0;
        do_suspend = 1'b0;
        do_resume  = 1'b0;
        do_delete  = 1'b0;
        do_count   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        MODE_TICK: begin
                            cmd_ready  = 1'b1;
                            start_tick = 1'b1;
                        end
                        MODE_CREATE: begin
                            cmd_ready  = out_free;
                            load_out   = out_free;
                            out_kind   = KIND_CREATE;
                            out_status = slot_free ? STATUS_OK : STATUS_TAKEN;
                            do_create  = out_free && slot_free;
                        end
                        MODE_SUSPEND: begin
                            cmd_ready  = 1'b1;
                            do_suspend = 1'b1;
                        end
                        MODE_RESUME: begin
                            cmd_ready = 1'b1;
                            do_resume = 1'b1;
                        end
                        MODE_DELETE: begin
                            cmd_ready = 1'b1;
                            do_delete = 1'b1;
                        end
                        default: cmd_ready = 1'b1;
                    endcase
                end
            end
            ST_SCAN: begin
                do_count = scan_go;
                load_out = fire_reg[scan_reg] && out_free;
                out_kind = KIND_DISPATCH;
                out_slot = SLOT_W'(scan_reg);
                // last dispatch when no later slot fires in this tick
                out_last = ~|((fire_reg >> scan_reg) >> 1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            fire_reg      <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                occupied_reg[i]  <= 1'b0;
                running_reg[i]   <= 1'b0;
                period_reg[i]    <= '0;
                countdown_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (start_tick) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    fire_reg[i] <= running_reg[i] && occupied_reg[i] &&
                                   (countdown_reg[i] == '0);
                end
            end
            if (do_create) begin
                occupied_reg[cidx]  <= cmd.has_func;
                running_reg[cidx]   <= 1'b1;
                period_reg[cidx]    <= cmd.period;
                countdown_reg[cidx] <= cmd.delay;
            end
            if (do_suspend) begin
                running_reg[cidx] <= 1'b0;
            end
            if (do_resume) begin
                running_reg[cidx] <= 1'b1;
            end
            if (do_delete) begin
                occupied_reg[cidx] <= 1'b0;
            end
            if (do_count && running_reg[scan_reg]) begin
                if (countdown_reg[scan_reg] == '0) begin
                    countdown_reg[scan_reg] <= period_reg[scan_reg] - TIME_W'(1);
                end else begin
                    countdown_reg[scan_reg] <= countdown_reg[scan_reg] - TIME_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_kind_reg   <= out_kind;
            out_slot_reg   <= out_slot;
            out_status_reg <= out_status;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SLOT_W - 1){1'b0}}, out_status_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/periodic_task_tick_scheduler_top.sv -----
// Periodic task tick scheduler. Commands arrive on the s_ stream (mode in
// s_tuser) and land in a two-entry command queue, so the input can take up
// to two transactions while the executor is busy or the result register is held.
// Suspend, resume and delete execute directly; create waits for a free result
// register and returns one status transaction. A tick starts a scan of the slot
// table, one slot per cycle while no due dispatch waits on a stalled m_ side
// (at most 8 slots are addressable). Dispatches leave in slot order and m_tlast
// marks the last one of a tick; a tick with nothing due gives no transaction.
module periodic_task_tick_scheduler_top
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // task_slot[2:0], period[18:3], first_delay[34:19], has_function[35], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_out[2:0], status[3], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int NUM_SLOTS = (TASK_SLOTS > MAX_SLOTS) ? MAX_SLOTS : TASK_SLOTS;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    ptts_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ptts_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/periodic_task_tick_scheduler_top_tb.sv -----
module periodic_task_tick_scheduler_top_tb;
    import ptts_pkg::*;

    localparam int TASK_SLOTS = 8;
    localparam int MAX_GAP    = 10;
    localparam int TAIL_WAIT  = 4 * MAX_SLOTS + 20;
    localparam int MODE_CODES = 1 << MODE_W;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] delay;
        logic              func;
        int                gap;
        bit                drain;
    } sched_cmd_t;

    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic              last;
    } sched_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    // scheduler image
    logic              sched_occupied [TASK_SLOTS];
    logic              sched_running  [TASK_SLOTS];
    logic [TIME_W-1:0] sched_period   [TASK_SLOTS];
    logic [TIME_W-1:0] sched_count    [TASK_SLOTS];

    sched_cmd_t    cmd_backlog[$];
    sched_result_t due_results[$];
    sched_cmd_t    cmd_on_bus;
    sched_cmd_t    cmd_next;
    bit            next_loaded;
    int            next_hold;
    int            cmds_total;
    int            cmds_taken;
    int            results_seen;
    int            stall_left;
    int            n_failed;

    periodic_task_tick_scheduler_top #(
        .TASK_SLOTS(TASK_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic apply_command(input sched_cmd_t c);
        sched_result_t r;
        logic [TASK_SLOTS-1:0] fired;
        int last_slot;
        fired = '0;
        last_slot = -1;
        case (c.mode)
            MODE_TICK: begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (sched_running[i]) begin
                        if (sched_count[i] == '0) begin
                            if (sched_occupied[i]) begin
                                fired[i] = 1'b1;
                                last_slot = i;
                            end
                            sched_count[i] = sched_period[i] - TIME_W'(1);
                        end else begin
                            sched_count[i] = sched_count[i] - TIME_W'(1);
                        end
                    end
                end
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (fired[i]) begin
                        r.kind   = KIND_DISPATCH;
                        r.slot   = SLOT_W'(i);
                        r.status = STATUS_OK;
                        r.last   = (i == last_slot);
                        due_results.push_back(r);
                    end
                end
            end
            MODE_CREATE: begin
                r.kind = KIND_CREATE;
                r.slot = c.slot;
                r.last = 1'b1;
                if (c.slot < TASK_SLOTS && !sched_occupied[c.slot]) begin
                    sched_period[c.slot]   = c.period;
                    sched_occupied[c.slot] = c.func;
                    sched_running[c.slot]  = 1'b1;
                    sched_count[c.slot]    = c.delay;
                    r.status = STATUS_OK;
                end else begin
                    r.status = STATUS_TAKEN;
                end
                due_results.push_back(r);
            end
            MODE_SUSPEND: if (c.slot < TASK_SLOTS) sched_running[c.slot] = 1'b0;
            MODE_RESUME:  if (c.slot < TASK_SLOTS) sched_running[c.slot] = 1'b1;
            MODE_DELETE:  if (c.slot < TASK_SLOTS) sched_occupied[c.slot] = 1'b0;
            default: ;
        endcase
    endtask

    task automatic add_cmd(input logic [MODE_W-1:0] mode, input int slot, input int period,
                           input int delay, input logic func, input bit quiet,
                           input bit drain);
        sched_cmd_t c;
        c.mode   = mode;
        c.slot   = SLOT_W'(slot);
        c.period = TIME_W'(period);
        c.delay  = TIME_W'(delay);
        c.func   = func;
        c.gap    = draw_gap(quiet);
        c.drain  = drain;
        cmd_backlog.push_back(c);
    endtask

    // driver
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            apply_command(cmd_on_bus);
            cmds_taken++;
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (!next_loaded && cmd_backlog.size() != 0 &&
                (!cmd_backlog[0].drain || due_results.size() == 0)) begin
                cmd_next    = cmd_backlog.pop_front();
                next_hold   = cmd_next.gap;
                next_loaded = 1'b1;
            end
            if (next_loaded && next_hold == 0) begin
                cmd_on_bus  = cmd_next;
                next_loaded = 1'b0;
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_next.mode;
                s_tdata  <= {4'b0, cmd_next.func, cmd_next.delay, cmd_next.period,
                             cmd_next.slot};
            end else begin
                if (next_loaded) next_hold--;
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display({"%0t: unexpected transaction: ",
                              "got kind %0d slot %0d status %0d last %0d"},
                             $time, m_tuser[0], m_tdata[2:0], m_tdata[3], m_tlast);
                    n_failed++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser[0] !== want.kind || m_tdata[2:0] !== want.slot ||
                        m_tdata[3] !== want.status || m_tlast !== want.last) begin
                        $display({"%0t: mismatch: ",
                                  "expected kind %0d slot %0d status %0d last %0d, ",
                                  "got kind %0d slot %0d status %0d last %0d"},
                                 $time, want.kind, want.slot, want.status, want.last,
                                 m_tuser[0], m_tdata[2:0], m_tdata[3], m_tlast);
                        n_failed++;
                    end
                end
                results_seen++;
                stall_left = draw_gap((results_seen / 25) % 3 == 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        int per;
        int dly;
        logic [MODE_W-1:0] md;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_TICK;
        m_tready    = 1'b0;
        next_loaded = 1'b0;
        next_hold   = 0;
        cmds_taken  = 0;
        results_seen = 0;
        stall_left  = 0;
        n_failed    = 0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            sched_occupied[i] = 1'b0;
            sched_running[i]  = 1'b0;
            sched_period[i]   = '0;
            sched_count[i]    = '0;
        end

        // directed: empty tick, taken slot, zero/max period, null task, flags, unused codes
        add_cmd(MODE_TICK,    0, 0,       0,       1'b0, 1'b1, 1'b0);
        add_cmd(MODE_CREATE,  0, 1,       0,       1'b1, 1'b1, 1'b0);
        add_cmd(MODE_CREATE,  0, 3,       2,       1'b1, 1'b1, 1'b0);
        add_cmd(MODE_CREATE,  7, 0,       0,       1'b1, 1'b0, 1'b0);
        add_cmd(MODE_CREATE,  3, 'hFFFF, 'hFFFF,  1'b0, 1'b0, 1'b0);
        add_cmd(MODE_CREATE,  5, 2,       0,       1'b0, 1'b0, 1'b0);
        add_cmd(MODE_CREATE,  5, 2,       1,       1'b1, 1'b0, 1'b0);
        add_cmd(MODE_TICK,    0, 'hFFFF, 'hFFFF,  1'b1, 1'b1, 1'b0);
        add_cmd(MODE_TICK,    0, 0,       0,       1'b0, 1'b1, 1'b0);
        add_cmd(MODE_SUSPEND, 0, 0,       0,       1'b0, 1'b0, 1'b0);
        add_cmd(MODE_TICK,    0, 0,       0,       1'b0, 1'b0, 1'b0);
        add_cmd(MODE_RESUME,  0, 0,       0,       1'b0, 1'b0, 1'b0);
        add_cmd(MODE_DELETE,  7, 0,       0,       1'b0, 1'b0, 1'b0);
        add_cmd(MODE_TICK,    0, 0,       0,       1'b0, 1'b1, 1'b0);
        add_cmd(MODE_CREATE,  7, 1,       0,       1'b1, 1'b1, 1'b0);
        add_cmd(MODE_CREATE,  3, 1,       0,       1'b1, 1'b1, 1'b0);
        for (int i = 1; i < TASK_SLOTS; i++)
            if (i != 3 && i != 5 && i != 7)
                add_cmd(MODE_CREATE, i, 1, 0, 1'b1, 1'b1, 1'b0);
        add_cmd(MODE_TICK,    0, 0,       0,       1'b0, 1'b1, 1'b0);
        for (int m = int'(MODE_DELETE) + 1; m < MODE_CODES; m++)
            add_cmd(MODE_W'(m), $urandom_range(0, 7), $urandom_range(0, 'hFFFF),
                    $urandom_range(0, 'hFFFF), 1'($urandom_range(0, 1)), 1'b0, 1'b0);

        // random
        for (int n = 0; n < 185; n++) begin
            r   = $urandom_range(0, 99);
            per = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 'hFFFF)
                                              : $urandom_range(0, 4);
            dly = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 'hFFFF)
                                              : $urandom_range(0, 5);
            if (r < 40)      md = MODE_TICK;
            else if (r < 65) md = MODE_CREATE;
            else if (r < 75) md = MODE_SUSPEND;
            else if (r < 85) md = MODE_RESUME;
            else if (r < 95) md = MODE_DELETE;
            else             md = MODE_W'($urandom_range(int'(MODE_DELETE) + 1, MODE_CODES - 1));
            add_cmd(md, $urandom_range(0, 7), per, dly, 1'($urandom_range(0, 6) != 0),
                    (n / 30) % 2 == 1, n % 60 == 0);
        end
        cmds_total = cmd_backlog.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken < cmds_total) @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (n_failed == 0 && due_results.size() == 0) begin
            $display("periodic_task_tick_scheduler_top_tb OK");
        end else begin
            $display("periodic_task_tick_scheduler_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("periodic_task_tick_scheduler_top_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ptts_pkg.sv
sv/ptts_front.sv
sv/ptts_back.sv
sv/periodic_task_tick_scheduler_top.sv
tb/periodic_task_tick_scheduler_top_tb.sv
